// ===== design/cumulative_trapezoid_lookup_table_defines.svh =====
// Assertion macros used by ctlt_back.
`ifndef CUMULATIVE_TRAPEZOID_LOOKUP_TABLE_DEFINES_SVH
`define CUMULATIVE_TRAPEZOID_LOOKUP_TABLE_DEFINES_SVH

`ifndef SYNTH

`define CTLT_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("ctlt: same-cycle check failed");

`define CTLT_ASSERT_NXT(name, clk_i, rstn_i, ante, cons) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("ctlt: next-cycle check failed");

`else

`define CTLT_ASSERT_IMP(name, clk_i, rstn_i, ante, cons)
`define CTLT_ASSERT_NXT(name, clk_i, rstn_i, ante, cons)

`endif

`endif

// ===== design/ctlt_pkg.sv =====
package ctlt_pkg;

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;
    localparam logic [15:0] TOL_RESET = 16'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_POSITION = 1'b0,
        REG_MATCH_TOL    = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ABOVE   = 3'd1,
        ST_NOMATCH = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4,
        ST_ORDER   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_LOAD_NEW    = 2'd0,
        OP_LOAD_APPEND = 2'd1,
        OP_QUERY       = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_MUL,
        S_LD_RND,
        S_LD_ACC,
        S_LD_WR,
        S_Q_ISSUE,
        S_Q_CMP,
        S_Q_END,
        S_Q_FETCH,
        S_DONE
    } back_state_t;

    typedef struct packed {
        logic               req_type;
        logic [31:0]        position;
        logic signed [31:0] func_value;
        logic               first_point;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [62:0] integral_value;
        logic [11:0] entry_index;
    } out_word_t;

    typedef struct packed {
        op_t                op;
        logic [31:0]        position;
        logic signed [31:0] func_value;
    } cmd_t;

    typedef struct packed {
        logic [31:0] reference_position;
        logic [15:0] match_tolerance;
    } cfg_t;

endpackage

// ===== design/ctlt_ram.sv =====
module ctlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/ctlt_fifo.sv =====
module ctlt_fifo #(
    parameter int DEPTH = ctlt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ctlt_pkg::cmd_t push_word,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output ctlt_pkg::cmd_t pop_word
);
    import ctlt_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full     = (cnt_reg == NW'(DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_word = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end
endmodule

// ===== design/ctlt_front.sv =====
module ctlt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ctlt_pkg::in_word_t in_word,
    output logic               push,
    output ctlt_pkg::cmd_t     push_word,
    input  logic               q_full
);
    import ctlt_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic accept;

    assign in_stall  = valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = valid_reg && !q_full;
    assign push_word = cmd_reg;

    // decode the request into a back-end command
    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next          = 1'b1;
            cmd_next.position   = in_word.position;
            cmd_next.func_value = in_word.func_value;
            if (in_word.req_type)
            begin
                cmd_next.op = OP_QUERY;
            end
            else if (in_word.first_point)
            begin
                cmd_next.op = OP_LOAD_NEW;
            end
            else
            begin
                cmd_next.op = OP_LOAD_APPEND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end
endmodule

// ===== design/ctlt_back.sv =====
`include "cumulative_trapezoid_lookup_table_defines.svh"

module ctlt_back #(
    parameter int TABLE_DEPTH = ctlt_pkg::DEF_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctlt_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  ctlt_pkg::cmd_t      q_word,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output ctlt_pkg::out_word_t out_word
);
    import ctlt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    back_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [63:0]   running_reg, running_next;
    logic [31:0]   prev_pos_reg, prev_pos_next;
    logic [31:0]   prev_val_reg, prev_val_next;
    logic [63:0]   ref_int_reg, ref_int_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;

    logic [31:0]   pos_reg, pos_next;
    logic [31:0]   fv_reg, fv_next;
    logic [31:0]   dx_reg, dx_next;
    logic [32:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [63:0]   prod_reg, prod_next;
    logic [48:0]   step_reg, step_next;
    out_word_t     res_reg, res_next;
    out_word_t     out_word_reg, out_word_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   pos_rdata;
    logic [63:0]   raw_rdata;

    logic [CW-1:0] span, mid;
    logic [32:0]   s_sum, s_mag;
    logic [64:0]   prod_full;
    logic [47:0]   q_rnd;
    logic [48:0]   step_val;
    logic [64:0]   sum65;
    logic [63:0]   sat64;
    logic [64:0]   diff65;
    logic [62:0]   integ;
    logic [31:0]   pdiff;
    logic [AW+11:0] idx_ext;

    ctlt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pos_reg),
        .rdata (pos_rdata)
    );

    ctlt_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_raw_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (running_reg),
        .rdata (raw_rdata)
    );

    assign span  = hi_reg - lo_reg;
    assign mid   = lo_reg + (span >> 1);
    assign s_sum = {prev_val_reg[31], prev_val_reg} + {q_word.func_value[31], q_word.func_value};
    assign s_mag = s_sum[32] ? (~s_sum + 33'd1) : s_sum;
    assign prod_full = 65'(dx_reg) * 65'(mag_reg);
    // round half away from zero on magnitude, then apply sign
    assign q_rnd    = {1'b0, prod_reg[63:17]} + {47'd0, prod_reg[16]};
    assign step_val = neg_reg ? (~{1'b0, q_rnd} + 49'd1) : {1'b0, q_rnd};
    assign sum65    = {running_reg[63], running_reg} + {{16{step_reg[48]}}, step_reg};
    assign sat64    = (sum65[64] != sum65[63])
                    ? (sum65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                    : sum65[63:0];
    assign diff65   = {raw_rdata[63], raw_rdata} - {ref_int_reg[63], ref_int_reg};
    assign integ    = (diff65[64] || (diff65 == '0)) ? '0
                    : (diff65[63] ? '1 : diff65[62:0]);
    assign pdiff    = pos_rdata - pos_reg;
    assign idx_ext  = {12'd0, idx_reg};

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        running_next   = running_reg;
        prev_pos_next  = prev_pos_reg;
        prev_val_next  = prev_val_reg;
        ref_int_next   = ref_int_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        fv_next        = fv_reg;
        dx_next        = dx_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_addr       = idx_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    pos_next = q_word.position;
                    fv_next  = q_word.func_value;
                    res_next.integral_value = '0;
                    res_next.entry_index    = '0;
                    if (q_word.op == OP_QUERY)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = S_Q_ISSUE;
                        end
                    end
                    else if (q_word.op == OP_LOAD_NEW || count_reg == '0)
                    begin
                        running_next = '0;
                        ref_int_next = '0;
                        idx_next     = '0;
                        state_next   = S_LD_WR;
                    end
                    else if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else if (q_word.position <= prev_pos_reg)
                    begin
                        res_next.status = ST_ORDER;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        dx_next    = q_word.position - prev_pos_reg;
                        mag_next   = s_mag;
                        neg_next   = s_sum[32];
                        idx_next   = count_reg[AW-1:0];
                        state_next = S_LD_MUL;
                    end
                end
            end
            S_LD_MUL:
            begin
                prod_next  = prod_full[63:0];
                state_next = S_LD_RND;
            end
            S_LD_RND:
            begin
                step_next  = step_val;
                state_next = S_LD_ACC;
            end
            S_LD_ACC:
            begin
                running_next = sat64;
                state_next   = S_LD_WR;
            end
            S_LD_WR:
            begin
                ram_we        = 1'b1;
                ram_addr      = idx_reg;
                prev_pos_next = pos_reg;
                prev_val_next = fv_reg;
                count_next    = CW'(idx_reg) + CW'(1);
                if (pos_reg <= cfg.reference_position)
                begin
                    ref_int_next = running_reg;
                end
                res_next.status         = ST_OK;
                res_next.integral_value = '0;
                res_next.entry_index    = idx_ext[11:0];
                state_next              = S_DONE;
            end
            S_Q_ISSUE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_addr   = mid[AW-1:0];
                    mid_next   = mid;
                    state_next = S_Q_CMP;
                end
                else
                begin
                    state_next = S_Q_END;
                end
            end
            S_Q_CMP:
            begin
                if (pos_rdata < pos_reg)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_Q_ISSUE;
            end
            S_Q_END:
            begin
                if (lo_reg >= count_reg)
                begin
                    res_next.status = ST_ABOVE;
                    state_next      = S_DONE;
                end
                else
                begin
                    ram_addr   = lo_reg[AW-1:0];
                    idx_next   = lo_reg[AW-1:0];
                    state_next = S_Q_FETCH;
                end
            end
            S_Q_FETCH:
            begin
                res_next.entry_index = idx_ext[11:0];
                if (pdiff > {16'd0, cfg.match_tolerance})
                begin
                    res_next.status = ST_NOMATCH;
                end
                else
                begin
                    res_next.status         = ST_OK;
                    res_next.integral_value = integ;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            running_reg   <= '0;
            prev_pos_reg  <= '0;
            prev_val_reg  <= '0;
            ref_int_reg   <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            running_reg   <= running_next;
            prev_pos_reg  <= prev_pos_next;
            prev_val_reg  <= prev_val_next;
            ref_int_reg   <= ref_int_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        fv_reg       <= fv_next;
        dx_reg       <= dx_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        step_reg     <= step_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    `CTLT_ASSERT_NXT(a_count_after_write, clk, rst_n, state_reg == S_LD_WR, count_reg == CW'($past(idx_reg)) + CW'(1))
    `CTLT_ASSERT_IMP(a_search_bounds, clk, rst_n, state_reg == S_Q_ISSUE, (lo_reg <= hi_reg) && (hi_reg <= count_reg))
    `CTLT_ASSERT_IMP(a_zero_unless_ok, clk, rst_n, out_valid_reg && (out_word_reg.status != ST_OK), out_word_reg.integral_value == '0)
    `CTLT_ASSERT_IMP(a_count_bound, clk, rst_n, state_reg == S_IDLE, count_reg <= CW'(TABLE_DEPTH))
endmodule

// ===== design/cumulative_trapezoid_lookup_table.sv =====
// Load: a first point is written in S_LD_WR; an append runs S_LD_MUL, S_LD_RND, S_LD_ACC
// and S_LD_WR. Query: up to 13 search levels (4096 entries), S_Q_END, S_Q_FETCH unless above max.
// Throughput: one item per back-end run; the binary search over the position
// memory (one read and one compare per level) bounds query rate.
// Reset: table empty, integrals and previous point cleared, tolerance 7,
// reference position 0; memories are not cleared, no sweep after reset.
module cumulative_trapezoid_lookup_table #(
    parameter int TABLE_DEPTH = ctlt_pkg::DEF_TABLE_DEPTH,
    parameter int QUEUE_DEPTH = ctlt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ctlt_pkg::in_word_t                   in_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ctlt_pkg::out_word_t                  out_word,
    input  logic                                 cfg_we,
    input  logic [ctlt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ctlt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ctlt_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push, q_full, q_valid, q_pop;
    cmd_t push_word, q_word;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_REF_POSITION: cfg_next.reference_position = cfg_data;
                REG_MATCH_TOL:    cfg_next.match_tolerance    = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference_position <= '0;
            cfg_reg.match_tolerance    <= TOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ctlt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .push      (push),
        .push_word (push_word),
        .q_full    (q_full)
    );

    ctlt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_word  (q_word)
    );

    ctlt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );
endmodule

// ===== tb/tb_cumulative_trapezoid_lookup_table.sv =====
`timescale 1ns / 1ps

module tb_cumulative_trapezoid_lookup_table;

    import ctlt_pkg::*;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam int   DEPTH     = DEF_TABLE_DEPTH;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   REPORT_LIMIT   = 10;
    localparam int   LONG_HOLD      = 150;
    localparam int   LONG_TABLE     = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_word_t out_word;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic in_fire;
    logic out_fire;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    cumulative_trapezoid_lookup_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [31:0]        pos_mem [0:DEPTH-1];
    logic signed [63:0] int_mem [0:DEPTH-1];
    int unsigned        row_count = 0;
    logic signed [63:0] run_int = '0;
    logic signed [63:0] ref_int = '0;
    logic [31:0]        last_pos = '0;
    logic signed [31:0] last_val = '0;
    logic [31:0]        ref_pos_cfg = '0;
    logic [15:0]        tol_cfg = TOL_RESET;

    in_word_t  item_queue [$];
    out_word_t pending_results [$];
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int hold_request = 0;

    // stimulus-side view of the table being built
    logic [31:0] gen_tab [$];
    logic [31:0] gen_last = '0;
    int unsigned gen_len = 0;
    int unsigned gen_step = 1;

    function automatic logic signed [63:0] trap_step(logic [31:0] dx, logic signed [32:0] s);
        logic signed [63:0] s64;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] q;
        s64 = s;
        mag = (s64 < 0) ? -s64 : s64;
        prod = {32'b0, dx} * mag;
        q = (prod >> 17) + ((prod >> 16) & 64'd1);
        return (s64 < 0) ? -q : q;
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64:63] == 2'b01)
            return {1'b0, {63{1'b1}}};
        if (sum[64:63] == 2'b10)
            return {1'b1, {63{1'b0}}};
        return sum[63:0];
    endfunction

    function automatic out_word_t apply_item(in_word_t w);
        out_word_t r;
        logic [31:0] idx;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic signed [63:0] raw;
        logic [63:0] diff;
        r = '0;
        r.status = ST_OK;
        if (w.req_type == REQ_LOAD) begin
            if (w.first_point || row_count == 0) begin
                run_int = '0;
                ref_int = '0;
                idx = 0;
            end else if (row_count >= DEPTH) begin
                r.status = ST_FULL;
                return r;
            end else if (w.position <= last_pos) begin
                r.status = ST_ORDER;
                return r;
            end else begin
                run_int = sat_add(run_int, trap_step(w.position - last_pos,
                    {last_val[31], last_val} + {w.func_value[31], w.func_value}));
                idx = row_count;
            end
            pos_mem[idx] = w.position;
            int_mem[idx] = run_int;
            if (w.position <= ref_pos_cfg)
                ref_int = run_int;
            last_pos = w.position;
            last_val = w.func_value;
            row_count = idx + 1;
            r.entry_index = idx[11:0];
            return r;
        end
        if (row_count == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        lo = 0;
        hi = row_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (pos_mem[mid] < w.position)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo >= row_count) begin
            r.status = ST_ABOVE;
            return r;
        end
        r.entry_index = lo[11:0];
        if (pos_mem[lo] - w.position > {16'b0, tol_cfg}) begin
            r.status = ST_NOMATCH;
            return r;
        end
        raw = int_mem[lo];
        if (raw > ref_int) begin
            diff = raw - ref_int;
            r.integral_value = diff[63] ? {63{1'b1}} : diff[62:0];
        end
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_fire)
                pending_results = {pending_results, apply_item(in_word)};
            if (!in_valid || !in_stall) begin
                if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_word  <= item_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and output backpressure
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        out_word_t exp_word;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_fire) begin
                if (pending_results.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result word: status %0d value %0h index %0d",
                            out_word.status, out_word.integral_value, out_word.entry_index);
                    mismatches++;
                end else begin
                    exp_word = pending_results.pop_front();
                    if (out_word.status !== exp_word.status
                        || out_word.integral_value !== exp_word.integral_value
                        || out_word.entry_index !== exp_word.entry_index) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("mismatch: exp st %0d val %0h idx %0d, got st %0d val %0h idx %0d",
                                exp_word.status, exp_word.integral_value, exp_word.entry_index,
                                out_word.status, out_word.integral_value, out_word.entry_index);
                        mismatches++;
                    end
                end
            end
            if (hold_seen != hold_request) begin
                hold_seen <= hold_request;
                hold_left <= LONG_HOLD;
                out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog: cycles without any accepted word
    int unsigned quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_fire || out_fire)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", quiet_cycles);
                $display("tb_cumulative_trapezoid_lookup_table NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_load(logic first, logic [31:0] pos, logic [31:0] fv);
        in_word_t w;
        w.req_type    = REQ_LOAD;
        w.position    = pos;
        w.func_value  = fv;
        w.first_point = first;
        item_queue = {item_queue, w};
        if (first || gen_tab.size() == 0) begin
            gen_tab = {pos};
            gen_last = pos;
        end else if (gen_tab.size() < DEPTH && pos > gen_last) begin
            gen_tab = {gen_tab, pos};
            gen_last = pos;
        end
    endtask

    task automatic push_query(logic [31:0] pos);
        in_word_t w;
        w.req_type    = REQ_QUERY;
        w.position    = pos;
        w.func_value  = $urandom();
        w.first_point = $urandom_range(1);
        item_queue = {item_queue, w};
    endtask

    // query at or just below a stored position, inside or just outside tolerance
    task automatic push_near_query();
        logic [31:0] p;
        int unsigned d;
        p = gen_tab[$urandom_range(gen_tab.size() - 1)];
        d = $urandom_range(tol_cfg + 2);
        push_query((p > d) ? p - d : 32'd0);
    endtask

    task automatic start_table();
        gen_len = $urandom_range(1, 48);
        case ($urandom_range(4))
            0: gen_step = 1;
            1: gen_step = 8;
            2: gen_step = 32'h100;
            3: gen_step = 32'h1_0000;
            default: gen_step = 32'h100_0000;
        endcase
        push_load(1'b1, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF),
            rand_value());
    endtask

    task automatic random_items(int n);
        int unsigned r;
        logic [31:0] step;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 4 || gen_tab.size() >= gen_len) begin
                start_table();
            end else if (r < 50) begin
                step = $urandom_range(1, gen_step);
                if (gen_last > 32'hFFFF_FFFF - step)
                    start_table();
                else
                    push_load(1'b0, gen_last + step, rand_value());
            end else if (r < 85) begin
                push_near_query();
            end else if (r < 90) begin
                if (gen_last == 32'hFFFF_FFFF)
                    push_query(gen_last);
                else
                    push_query($urandom_range(32'hFFFF_FFFF, gen_last + 1));
            end else if (r < 94) begin
                push_query($urandom());
            end else if (r < 97) begin
                push_load(1'b0, $urandom_range(gen_last, 0), rand_value());
            end else begin
                push_load($urandom_range(1), $urandom(), rand_value());
            end
        end
    endtask

    task automatic fill_table();
        logic [31:0] p;
        int k;
        p = $urandom_range(0, 32'h00FF_FFFF);
        push_load(1'b1, p, rand_value());
        for (k = 1; k < LONG_TABLE; k++) begin
            p = p + $urandom_range(1, 32'h0007_FFFF);
            push_load(1'b0, p, rand_value());
        end
        repeat (3) push_load(1'b0, p + $urandom_range(1, 1000), rand_value());
        push_load(1'b0, p, rand_value());
        repeat (60) push_near_query();
        push_query(p + 1);
        push_query(32'hFFFF_FFFF);
        push_query(32'd0);
        gen_len = 0;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_REF_POSITION)
            ref_pos_cfg = val;
        else
            tol_cfg = val[15:0];
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (item_queue.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (12) @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: empty table, load into empty table, order, clamp
        push_query(32'd0);
        push_query(32'hFFFF_FFFF);
        push_load(1'b0, 32'h0001_0000, 32'h7FFF_FFFF);
        push_load(1'b0, 32'h0001_0000, 32'h0000_1000);
        push_load(1'b0, 32'h0000_8000, 32'h0000_1000);
        push_load(1'b0, 32'h0002_0000, 32'h7FFF_FFFF);
        push_load(1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
        push_query(32'h0001_0000);
        push_query(32'h0001_FFFC);
        push_query(32'h0001_FFF0);
        push_query(32'd0);
        push_query(32'hFFFF_FFFF);
        push_load(1'b1, 32'd0, 32'h8000_0000);
        push_load(1'b0, 32'h0001_0000, 32'h8000_0000);
        push_query(32'h0001_0000);
        drain();

        write_reg(REG_REF_POSITION, 32'h0001_8000);
        write_reg(REG_MATCH_TOL, 32'd0);
        push_load(1'b1, 32'h0001_0000, 32'h0001_0000);
        push_load(1'b0, 32'h0001_8000, 32'h0002_0000);
        push_load(1'b0, 32'h0002_0000, 32'h7FFF_FFFF);
        push_query(32'h0002_0000);
        push_query(32'h0001_FFFF);
        push_query(32'h0001_0000);
        push_query(32'h0002_0001);
        drain();

        write_reg(REG_REF_POSITION, $urandom_range(0, 32'h0200_0000));
        write_reg(REG_MATCH_TOL, $urandom_range(0, 64));
        send_idle_pct = 35;
        recv_idle_pct = 72;
        random_items(350);
        drain();

        write_reg(REG_REF_POSITION, 32'hFFFF_FFFF);
        write_reg(REG_MATCH_TOL, 32'h0000_FFFF);
        send_idle_pct = 72;
        recv_idle_pct = 35;
        random_items(350);
        drain();

        write_reg(REG_REF_POSITION, 32'h2000_0000);
        write_reg(REG_MATCH_TOL, 32'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_table();
        hold_request++;
        random_items(350);
        drain();

        repeat (40) @(negedge clk);
        if (pending_results.size() != 0) begin
            $display("%0d result words never arrived", pending_results.size());
            mismatches += pending_results.size();
        end
        if (mismatches == 0)
            $display("tb_cumulative_trapezoid_lookup_table OK");
        else
            $display("tb_cumulative_trapezoid_lookup_table NOT OK");
        $finish;
    end

endmodule
